// File: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Square spiral position package
// Shared types, widths and defaults for the spiral position block.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Field widths of the stream items
    localparam int unsigned COORD_W = 32;
    localparam int unsigned INDEX_W = 16;

    // Packed stream widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 96;

    // Parameter defaults
    localparam int unsigned MAX_INDEX_DEF = 65535;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture input item, clear walk
        logic step;   // advance one unit step
        logic emit;   // load result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic done;   // all steps of the item taken
    } t_sts;

endpackage

// File: rtl/square_spiral_position_top.sv
// ----------------------------------------------------------------------------
// The spiral walk takes one unit step per cycle through the datapath step
//   counter. A new item is accepted only once the last one has been handed to
//   the output register; the next item is accepted while that finished result
//   still waits in the output register. Reset (i_rst_n low, synchronous) drops
//   any item in flight and clears the output valid; the block then stands ready
//   for an item.
// ----------------------------------------------------------------------------
// Square spiral position, top level
// Returns the start position moved n unit steps along a square spiral in x-z.
// ----------------------------------------------------------------------------
module square_spiral_position_top #(
    parameter int unsigned MAX_INDEX = ssp_pkg::MAX_INDEX_DEF,
    parameter int unsigned FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input item stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata, low bit up: start_x[31:0], start_y[63:32], start_z[95:64],
    //   spiral_index[111:96]
    input  logic [ssp_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Result item stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata, low bit up: pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic [ssp_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int unsigned CW = ssp_pkg::COORD_W;

    ssp_pkg::t_cmd       cmd;
    ssp_pkg::t_sts       sts;
    logic signed [CW-1:0] pos_x, pos_y, pos_z;

    // Controller: accept, step until the walk is done, hand off to the output
    ssp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Datapath: capture the item fields, walk the spiral, saturate into the result register
    ssp_dpath #(
        .MAX_INDEX (MAX_INDEX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start_x      (i_s_axis_tdata[CW-1:0]),
        .i_start_y      (i_s_axis_tdata[2*CW-1:CW]),
        .i_start_z      (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_spiral_index (i_s_axis_tdata[3*CW+ssp_pkg::INDEX_W-1:3*CW]),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_pos_z        (pos_z)
    );

    // Pack the result fields, x lowest
    assign o_m_axis_tdata = {pos_z, pos_y, pos_x};

    // An accepted item keeps the input side closed in the following cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input accepted again right after an accept");

    // A zero-step item with a free output shows its result once ST_RUN has emitted it into the output register
    a_zero_index_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid &&
         (i_s_axis_tdata[3*CW+ssp_pkg::INDEX_W-1:3*CW] == '0))
        |=> ##1 o_m_axis_tvalid
    ) else $error("zero-step item did not produce a result in time");

    // The controller loads the result register only while the walk is done
    a_emit_when_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (sts.done && !cmd.step && !cmd.load)
    ) else $error("result loaded before the walk finished");

endmodule

// File: rtl/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// Square spiral controller
// Sequences accept, stepping and result hand-off; owns the output valid.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    input  ssp_pkg::t_sts i_sts,
    output ssp_pkg::t_cmd o_cmd
);

    ssp_pkg::t_state r_state;
    ssp_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_ready  = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ssp_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ssp_pkg::ST_RUN;
                end
            end
            ssp_pkg::ST_RUN: begin
                if (i_sts.done) begin
                    // hold until the result register can take the item
                    if (out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = ssp_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ssp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

// File: rtl/ssp_dpath.sv
// ----------------------------------------------------------------------------
// Square spiral datapath
// Walks the spiral one unit step per cycle while the step command is high and forms the result, x and z saturated.
// ----------------------------------------------------------------------------
module ssp_dpath #(
    parameter int unsigned MAX_INDEX = ssp_pkg::MAX_INDEX_DEF,
    parameter int unsigned FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  ssp_pkg::t_cmd                        i_cmd,
    output ssp_pkg::t_sts                        o_sts,
    input  logic signed [ssp_pkg::COORD_W-1:0]   i_start_x,
    input  logic signed [ssp_pkg::COORD_W-1:0]   i_start_y,
    input  logic signed [ssp_pkg::COORD_W-1:0]   i_start_z,
    input  logic        [ssp_pkg::INDEX_W-1:0]   i_spiral_index,
    output logic signed [ssp_pkg::COORD_W-1:0]   o_pos_x,
    output logic signed [ssp_pkg::COORD_W-1:0]   o_pos_y,
    output logic signed [ssp_pkg::COORD_W-1:0]   o_pos_z
);

    localparam int unsigned IDX_W = $clog2(MAX_INDEX + 1);
    localparam int unsigned CNT_W = IDX_W + 2;
    localparam int unsigned D_W   = IDX_W + 1;
    localparam int unsigned SUM_W = (D_W + FRAC_BITS > ssp_pkg::COORD_W)
                                  ? D_W + FRAC_BITS + 2 : ssp_pkg::COORD_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'(signed'({1'b0, {(ssp_pkg::COORD_W-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        SUM_W'(signed'({1'b1, {(ssp_pkg::COORD_W-1){1'b0}}}));

    // Unit direction in the x-z plane
    typedef enum logic [1:0] {
        DIR_PZ = 2'd0,
        DIR_PX = 2'd1,
        DIR_MZ = 2'd2,
        DIR_MX = 2'd3
    } t_dir;

    logic signed [ssp_pkg::COORD_W-1:0] r_sx, r_sy, r_sz;
    logic        [IDX_W-1:0]            r_n;
    logic        [CNT_W-1:0]            r_i, n_i;
    logic        [CNT_W-1:0]            r_turn_at, n_turn_at;
    logic        [CNT_W-1:0]            r_flip_at, n_flip_at;
    logic        [CNT_W-1:0]            r_run, n_run;
    t_dir                               r_dir, n_dir, flip_dir;
    logic signed [D_W-1:0]              r_dx, n_dx, r_dz, n_dz;
    logic        [IDX_W-1:0]            load_n;
    logic signed [SUM_W-1:0]            sum_x, sum_z;
    logic signed [ssp_pkg::COORD_W-1:0] sat_x, sat_z;

    // Clamp the index to the configured maximum
    always_comb begin
        if (32'(i_spiral_index) > 32'(MAX_INDEX)) begin
            load_n = IDX_W'(MAX_INDEX);
        end else begin
            load_n = IDX_W'(i_spiral_index);
        end
    end

    assign o_sts.done = (r_i == CNT_W'(r_n));

    // One unit step: move, then reverse on a flip index, then rotate on a turn index
    always_comb begin
        n_i       = r_i + CNT_W'(1);
        n_dx      = r_dx;
        n_dz      = r_dz;
        n_run     = r_run;
        n_flip_at = r_flip_at;
        n_turn_at = r_turn_at;
        case (r_dir)
            DIR_PZ:  n_dz = r_dz + D_W'(1);
            DIR_PX:  n_dx = r_dx + D_W'(1);
            DIR_MZ:  n_dz = r_dz - D_W'(1);
            DIR_MX:  n_dx = r_dx - D_W'(1);
            default: n_dz = r_dz;
        endcase
        flip_dir = r_dir;
        if (n_i == r_flip_at) begin
            flip_dir  = t_dir'(r_dir + 2'd2);
            n_run     = r_run + CNT_W'(1);
            n_flip_at = r_flip_at + (n_run << 1);
        end
        n_dir = flip_dir;
        if (n_i == r_turn_at) begin
            case (flip_dir)
                DIR_PZ:  n_dir = DIR_PX;
                DIR_PX:  n_dir = DIR_PZ;
                DIR_MZ:  n_dir = DIR_MX;
                DIR_MX:  n_dir = DIR_MZ;
                default: n_dir = DIR_PZ;
            endcase
            n_turn_at = r_turn_at + n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx      <= i_start_x;
            r_sy      <= i_start_y;
            r_sz      <= i_start_z;
            r_n       <= load_n;
            r_i       <= '0;
            r_dx      <= '0;
            r_dz      <= '0;
            r_dir     <= DIR_PZ;
            r_run     <= CNT_W'(1);
            r_turn_at <= CNT_W'(1);
            r_flip_at <= CNT_W'(2);
        end else if (i_cmd.step) begin
            r_i       <= n_i;
            r_dx      <= n_dx;
            r_dz      <= n_dz;
            r_dir     <= n_dir;
            r_run     <= n_run;
            r_turn_at <= n_turn_at;
            r_flip_at <= n_flip_at;
        end
    end

    // Scale the offset to fixed point, add, clamp
    assign sum_x = SUM_W'(r_sx) + (SUM_W'(r_dx) <<< FRAC_BITS);
    assign sum_z = SUM_W'(r_sz) + (SUM_W'(r_dz) <<< FRAC_BITS);

    always_comb begin
        if (sum_x > SAT_MAX) begin
            sat_x = SAT_MAX[ssp_pkg::COORD_W-1:0];
        end else if (sum_x < SAT_MIN) begin
            sat_x = SAT_MIN[ssp_pkg::COORD_W-1:0];
        end else begin
            sat_x = sum_x[ssp_pkg::COORD_W-1:0];
        end
        if (sum_z > SAT_MAX) begin
            sat_z = SAT_MAX[ssp_pkg::COORD_W-1:0];
        end else if (sum_z < SAT_MIN) begin
            sat_z = SAT_MIN[ssp_pkg::COORD_W-1:0];
        end else begin
            sat_z = sum_z[ssp_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pos_x <= sat_x;
            o_pos_y <= r_sy;
            o_pos_z <= sat_z;
        end
    end

endmodule
